### rtl/core/lpd_pkg.sv
// Shared types and constants of the Laplacian point detector.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;

  localparam int PIX_W       = 8;
  localparam int WIDTH_W     = 13;
  localparam int HEIGHT_W    = 16;
  localparam int THR_W       = 11;
  localparam int RESP_W      = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_THRESHOLD = 2'd2;

  localparam logic [WIDTH_W-1:0]  RESET_FRAME_WIDTH     = 13'd512;
  localparam logic [HEIGHT_W-1:0] RESET_FRAME_HEIGHT    = 16'd512;
  localparam logic [THR_W-1:0]    RESET_POINT_THRESHOLD = 11'd1000;

  localparam logic [WIDTH_W-1:0]  MIN_FRAME_WIDTH  = 13'd3;
  localparam logic [HEIGHT_W-1:0] MIN_FRAME_HEIGHT = 16'd3;

  // Input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Result queue: power-of-two depth
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [RESP_W-1:0] response;
    logic              is_point;
    logic              last_in_frame;
  } out_t;

  // Result control for one window position, from the read stage to the window
  typedef struct packed {
    logic valid;
    logic col_is_one;
    logic last_col;
    logic drain;
  } emit_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/lpd_line_buffer.sv
// Two line buffer memories (row above, row middle) with registered read.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_line_buffer
  import lpd_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [PIX_W-1:0] rd_above,
  output logic      [PIX_W-1:0] rd_middle,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [PIX_W-1:0] wr_above,
  input  wire logic [PIX_W-1:0] wr_middle
);

  logic [PIX_W-1:0] above_mem  [DEPTH];
  logic [PIX_W-1:0] middle_mem [DEPTH];

  // Read both rows at the column of the incoming pixel
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_above  <= above_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

  // Write back: middle moves up, new pixel becomes middle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr]  <= wr_above;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lpd_window.sv
// 3x3 window registers and the Laplacian response/threshold stage.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_window
  import lpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift_en,
  input  wire logic [PIX_W-1:0] col_top,
  input  wire logic [PIX_W-1:0] col_center,
  input  wire logic [PIX_W-1:0] col_bottom,
  input  wire emit_ctrl_t       emit_in,
  input  wire logic [THR_W-1:0] point_threshold,
  output out_t                  result_first,
  output out_t                  result_second,
  output logic [1:0]            push_count
);

  logic [PIX_W-1:0] win [3][3];
  emit_ctrl_t       emit;
  logic [9:0]       col_sum [3];

  // Shift the window left and load the new column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= col_top;
      win[1][2] <= col_center;
      win[2][2] <= col_bottom;
    end
  end

  // Hold the result control alongside the updated window
  always_ff @(posedge clk) begin
    if (rst) begin
      emit <= '0;
    end else begin
      emit <= emit_in;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_sum[c] = 10'(win[0][c]) + 10'(win[1][c]) + 10'(win[2][c]);
    end
  end

  // Neighbors: two outer column sums plus top and bottom of the center column
  function automatic out_t calc_point(
    input logic [9:0]       sum_a,
    input logic [9:0]       sum_c,
    input logic [PIX_W-1:0] top,
    input logic [PIX_W-1:0] center,
    input logic [PIX_W-1:0] bottom,
    input logic [THR_W-1:0] thr,
    input logic             last
  );
    logic [RESP_W-1:0] nsum;
    logic [RESP_W-1:0] center8;
    logic [RESP_W-1:0] v;
    out_t              res;
    nsum    = RESP_W'(sum_a) + RESP_W'(sum_c) + RESP_W'(top) + RESP_W'(bottom);
    center8 = {center, 3'b000};
    v       = (nsum > center8) ? (nsum - center8) : '0;
    res.is_point      = (v >= thr);
    res.response      = res.is_point ? v : '0;
    res.last_in_frame = last;
    return res;
  endfunction

  // Reflect the left border on the first output column
  always_comb begin
    result_first = calc_point(emit.col_is_one ? col_sum[2] : col_sum[0], col_sum[2],
                              win[0][1], win[1][1], win[2][1], point_threshold, 1'b0);
    // Right border result reflects column 1 on both sides
    result_second = calc_point(col_sum[1], col_sum[1],
                               win[0][2], win[1][2], win[2][2], point_threshold,
                               emit.drain);
    push_count = {1'b0, emit.valid} + {1'b0, emit.valid & emit.last_col};
  end

endmodule

`default_nettype wire

### rtl/core/lpd_result_fifo.sv
// Result queue: up to two pushes and one pop per cycle.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_result_fifo
  import lpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         push_count,
  input  wire out_t               push_first,
  input  wire out_t               push_second,
  input  wire logic               pop,
  output out_t                    head_data,
  output logic                    not_empty,
  output logic [FIFO_CW-1:0]      count
);

  out_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head;
  logic [FIFO_AW-1:0] tail;
  logic               do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head_data = entries[head];

  // Store the new results in order
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[tail] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[tail + FIFO_AW'(1)] <= push_second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + FIFO_AW'(push_count);
      head  <= head + FIFO_AW'(do_pop);
      count <= count + FIFO_CW'(push_count) - FIFO_CW'(do_pop);
    end
  end

endmodule

`default_nettype wire

### rtl/core/laplacian_point_detector.sv
// Top level of the 3x3 Laplacian isolated-point detector.
// Depends on lpd_pkg, lpd_line_buffer, lpd_window and lpd_result_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Streams 8-bit grey pixels in raster order and returns, per pixel, the sum of its
// eight neighbors minus eight times the pixel, with reflect-101 borders, negative
// values clamped to zero and values below point_threshold forced to zero (is_point
// marks the others). Results trail the input by one row: after the frame's last
// pixel, send frame_width drain transactions (kind = 1) to flush the final row.
// One input transaction is taken every clock; a pixel reads both line buffers as
// it is taken, the window and write-back follow in the next cycle and the
// result enters a small output queue the cycle after that. The last pixel of a row
// yields two results, so the queue briefly holds back input only if the consumer
// stalls. Line buffers are not cleared; the first two rows of a frame fill them.

module laplacian_point_detector
  import lpd_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_t                    in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_t                        out_data,
  input  wire logic                   cfg_write_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int                 AW        = $clog2(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0] MAX_W_CFG = WIDTH_W'(MAX_WIDTH);

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [THR_W-1:0]    point_threshold;

  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;

  logic [AW-1:0]       column_count;
  logic [AW-1:0]       column_count_next;
  logic [HEIGHT_W-1:0] row_count;
  logic [HEIGHT_W-1:0] row_count_next;

  logic accept;
  logic drain_phase;
  logic effective;
  logic last_col;

  // Read stage registers
  logic             s1_valid;
  logic             s1_drain;
  logic             s1_row_one;
  logic             s1_gen;
  logic             s1_col_is_one;
  logic             s1_last_col;
  logic [PIX_W-1:0] s1_pixel;
  logic [AW-1:0]    s1_addr;

  logic [PIX_W-1:0] rd_above;
  logic [PIX_W-1:0] rd_middle;
  logic [PIX_W-1:0] col_top;
  logic [PIX_W-1:0] col_bottom;
  emit_ctrl_t       emit_ctrl;

  out_t               result_first;
  out_t               result_second;
  logic [1:0]         push_count;
  logic [FIFO_CW-1:0] fifo_count;
  logic [FIFO_CW:0]   fifo_need;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RESET_FRAME_WIDTH;
      frame_height    <= RESET_FRAME_HEIGHT;
      point_threshold <= RESET_POINT_THRESHOLD;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:     frame_width     <= cfg_data[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[HEIGHT_W-1:0];
        CFG_POINT_THRESHOLD: point_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame geometry
  always_comb begin
    priority if (frame_width < MIN_FRAME_WIDTH) begin
      width_eff = MIN_FRAME_WIDTH;
    end else if (frame_width > MAX_W_CFG) begin
      width_eff = MAX_W_CFG;
    end else begin
      width_eff = frame_width;
    end
    height_eff = (frame_height < MIN_FRAME_HEIGHT) ? MIN_FRAME_HEIGHT : frame_height;
  end

  // Reserve queue room for every result still in flight plus this transaction
  assign fifo_need = (FIFO_CW + 1)'(fifo_count) + (FIFO_CW + 1)'({s1_valid, 1'b0})
                   + (FIFO_CW + 1)'(push_count) + (FIFO_CW + 1)'(2);
  assign in_ready  = (fifo_need <= (FIFO_CW + 1)'(FIFO_DEPTH));
  assign accept    = in_valid && in_ready;

  assign drain_phase = (row_count >= height_eff);
  assign effective   = (in_data.kind == KIND_PIXEL && !drain_phase) ||
                       (in_data.kind == KIND_DRAIN && drain_phase);
  assign last_col    = (WIDTH_W'(column_count) + WIDTH_W'(1)) >= width_eff;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept && effective) begin
      if (last_col) begin
        column_count_next = '0;
        row_count_next    = drain_phase ? '0 : row_count + HEIGHT_W'(1);
      end else begin
        column_count_next = column_count + AW'(1);
      end
    end
  end

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Capture the transaction while the line buffers are read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && effective;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_drain      <= drain_phase;
      s1_row_one    <= (row_count == HEIGHT_W'(1));
      s1_gen        <= (drain_phase || row_count != '0) && column_count != '0;
      s1_col_is_one <= (column_count == AW'(1));
      s1_last_col   <= last_col;
      s1_pixel      <= in_data.pixel;
      s1_addr       <= column_count;
    end
  end

  lpd_line_buffer #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buffer (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (column_count),
    .rd_above  (rd_above),
    .rd_middle (rd_middle),
    .wr_en     (s1_valid && !s1_drain),
    .wr_addr   (s1_addr),
    .wr_above  (rd_middle),
    .wr_middle (s1_pixel)
  );

  // Build the new window column; reflect the top and bottom borders
  always_comb begin
    if (s1_drain) begin
      col_top    = rd_above;
      col_bottom = rd_above;
    end else begin
      col_top    = s1_row_one ? s1_pixel : rd_above;
      col_bottom = s1_pixel;
    end
    emit_ctrl.valid      = s1_valid && s1_gen;
    emit_ctrl.col_is_one = s1_col_is_one;
    emit_ctrl.last_col   = s1_last_col;
    emit_ctrl.drain      = s1_drain;
  end

  lpd_window u_window (
    .clk             (clk),
    .rst             (rst),
    .shift_en        (s1_valid),
    .col_top         (col_top),
    .col_center      (rd_middle),
    .col_bottom      (col_bottom),
    .emit_in         (emit_ctrl),
    .point_threshold (point_threshold),
    .result_first    (result_first),
    .result_second   (result_second),
    .push_count      (push_count)
  );

  lpd_result_fifo u_result_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (result_first),
    .push_second (result_second),
    .pop         (out_ready),
    .head_data   (out_data),
    .not_empty   (out_valid),
    .count       (fifo_count)
  );

  // Queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Raster column stays inside the line buffers
  assert property (@(posedge clk) disable iff (rst)
    32'(column_count) < MAX_WIDTH)
    else $error("column index beyond line buffer depth");

  // A rejected point carries a zero response
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_point |-> out_data.response == '0)
    else $error("nonzero response below threshold");

  // The last drain transaction of a frame restarts at the top row
  assert property (@(posedge clk) disable iff (rst)
    accept && effective && drain_phase && last_col |=> row_count == '0 && column_count == '0)
    else $error("frame did not restart after drain");

endmodule

`default_nettype wire

### tb/lpd_checker.sv
// Result checker for the Laplacian point detector: watches the pixel, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_checker
  import lpd_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_t                    in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_t                   out_data,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     error_count,
  output int                     results_outstanding
);

  // Shadow copy of the line buffers, window and raster position
  logic [PIX_W-1:0]    line_above  [MAX_WIDTH];
  logic [PIX_W-1:0]    line_middle [MAX_WIDTH];
  int                  window [3][3];
  int                  col_pos;
  int                  row_pos;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [THR_W-1:0]    threshold_reg;
  out_t                expected_points [$];
  int                  errors = 0;

  task automatic clear_model();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i]  = '0;
      line_middle[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        window[r][c] = 0;
      end
    end
    col_pos       = 0;
    row_pos       = 0;
    width_reg     = RESET_FRAME_WIDTH;
    height_reg    = RESET_FRAME_HEIGHT;
    threshold_reg = RESET_POINT_THRESHOLD;
    expected_points.delete();
  endtask

  // Eight neighbors minus eight times the center; columns a and c flank center column b
  function automatic out_t laplacian_at(int a, int b, int c, logic last_flag);
    int   sum;
    out_t res;
    sum = window[0][a] + window[1][a] + window[2][a] + window[0][b] + window[2][b]
        + window[0][c] + window[1][c] + window[2][c] - 8 * window[1][b];
    if (sum < 0) sum = 0;
    res.is_point      = (sum >= int'(threshold_reg));
    res.response      = res.is_point ? RESP_W'(sum) : '0;
    res.last_in_frame = last_flag;
    return res;
  endfunction

  task automatic predict_laplacian(input in_t item);
    int   w;
    int   h;
    int   idx;
    int   top;
    int   cen;
    int   bot;
    logic drain;
    logic last_col;
    w = int'(width_reg);
    if (w < int'(MIN_FRAME_WIDTH)) w = int'(MIN_FRAME_WIDTH);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = int'(height_reg);
    if (h < int'(MIN_FRAME_HEIGHT)) h = int'(MIN_FRAME_HEIGHT);
    drain = (row_pos >= h);

    // Drop pixels during the flush and drain ticks before the frame is complete
    if ((item.kind == KIND_DRAIN) != drain) return;

    idx = col_pos % MAX_WIDTH;
    top = line_above[idx];
    cen = line_middle[idx];
    if (drain) begin
      bot = top;
    end else begin
      bot = item.pixel;
      if (row_pos == 1) top = bot;
      line_above[idx]  = cen[PIX_W-1:0];
      line_middle[idx] = item.pixel;
    end

    // Advance the window by one column
    for (int r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = top;
    window[1][2] = cen;
    window[2][2] = bot;

    last_col = (col_pos + 1 >= w);
    if ((drain || row_pos >= 1) && col_pos >= 1) begin
      if (col_pos == 1) expected_points.push_back(laplacian_at(2, 1, 2, 1'b0));
      else expected_points.push_back(laplacian_at(0, 1, 2, 1'b0));
      if (last_col) expected_points.push_back(laplacian_at(1, 2, 1, drain));
    end

    if (last_col) begin
      col_pos = 0;
      row_pos = drain ? 0 : (row_pos + 1) & 16'hFFFF;
    end else begin
      col_pos = (col_pos + 1) & 12'hFFF;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_points.size() == 0) begin
      $error("unexpected result: response %0d, is_point %0d, last_in_frame %0d",
             got.response, got.is_point, got.last_in_frame);
      errors++;
    end else begin
      want = expected_points.pop_front();
      if (got.response !== want.response) begin
        $error("response: expected %0d, actual %0d", want.response, got.response);
        errors++;
      end
      if (got.is_point !== want.is_point) begin
        $error("is_point: expected %0d, actual %0d", want.is_point, got.is_point);
        errors++;
      end
      if (got.last_in_frame !== want.last_in_frame) begin
        $error("last_in_frame: expected %0d, actual %0d", want.last_in_frame,
               got.last_in_frame);
        errors++;
      end
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_FRAME_WIDTH:     width_reg     = data[WIDTH_W-1:0];
      CFG_FRAME_HEIGHT:    height_reg    = data[HEIGHT_W-1:0];
      CFG_POINT_THRESHOLD: threshold_reg = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Retire results before predicting: a result never comes from the same-edge transaction
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) predict_laplacian(in_data);
      if (cfg_write_en) write_register(cfg_index, cfg_data);
    end
    error_count         <= errors;
    results_outstanding <= expected_points.size();
  end

endmodule

### tb/tb.sv
// Testbench top for the Laplacian point detector: drives directed and random frames
// with random idling on both channels and gives the verdict.
// Depends on lpd_pkg, laplacian_point_detector and lpd_checker.
`timescale 1ns / 1ps

module tb;
  import lpd_pkg::*;

  localparam int RANDOM_ITEMS  = 860;
  localparam int SETTLE_CYCLES = 8;
  localparam int LINE_MAX      = DEFAULT_MAX_WIDTH;

  typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_SPARSE, PIX_FLAT} pixel_mode_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   steady = 1'b0;
  int                     error_count;
  int                     results_outstanding;
  int                     sent_items = 0;
  int                     stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  laplacian_point_detector dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  lpd_checker lpd_watch (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .error_count         (error_count),
    .results_outstanding (results_outstanding)
  );

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // Throttle the result channel
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [PIX_W-1:0] next_pixel(pixel_mode_t mode);
    case (mode)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_SPARSE:  return ($urandom_range(0, 11) == 0) ? $urandom_range(200, 255)
                                                       : $urandom_range(0, 30);
      PIX_FLAT:    return $urandom_range(120, 124);
      default:     return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int eff_width(int cfg);
    if (cfg < int'(MIN_FRAME_WIDTH)) return int'(MIN_FRAME_WIDTH);
    if (cfg > LINE_MAX) return LINE_MAX;
    return cfg;
  endfunction

  function automatic int eff_height(int cfg);
    return (cfg < int'(MIN_FRAME_HEIGHT)) ? int'(MIN_FRAME_HEIGHT) : cfg;
  endfunction

  // Present one transaction, after an optional gap, and hold it until accepted
  task automatic send_item(input logic kind, input logic [PIX_W-1:0] pixel);
    int  gap;
    in_t item;
    gap = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_length();
    item.kind  = kind;
    item.pixel = pixel;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_results_done();
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  task automatic hold_for_results();
    in_valid <= 1'b0;
    wait_results_done();
  endtask

  // Stop sending, let every result out, then give the pipeline time to empty
  task automatic settle();
    in_valid <= 1'b0;
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int width, input int height, input int threshold);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_FRAME_WIDTH;
    cfg_data     <= CFG_DATA_W'(width);
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= CFG_DATA_W'(height);
    @(posedge clk);
    cfg_index <= CFG_POINT_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(threshold);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Raster rows of pixels; stray drain ticks mixed in when noisy
  task automatic send_rows(input int w, input int rows, input pixel_mode_t mode,
                           input bit noisy, input int hold_row);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < w; c++) begin
        if (noisy && $urandom_range(0, 39) == 0) send_item(KIND_DRAIN, $urandom_range(0, 255));
        if (r == hold_row && c == w / 2) hold_for_results();
        send_item(KIND_PIXEL, next_pixel(mode));
        sent_items++;
      end
    end
  endtask

  // Flush the last row; stray pixels mixed in when noisy
  task automatic send_drains(input int w, input bit noisy);
    for (int c = 0; c < w; c++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_item(KIND_PIXEL, $urandom_range(0, 255));
      send_item(KIND_DRAIN, $urandom_range(0, 255));
      sent_items++;
    end
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] ring [9] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                                   8'hFF, 8'hFF, 8'hFF, 8'hFF};
    int               w_cfg;
    int               h_cfg;
    int               thr_cfg;
    int               frames;
    int               hold_row;
    int               random_start;
    pixel_mode_t      mode;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame at zero threshold: dark center in a bright ring, reflected borders,
    // a drain tick too early and a pixel during the flush
    configure(3, 3, 0);
    send_item(KIND_DRAIN, 8'h5A);
    for (int i = 0; i < 9; i++) send_item(KIND_PIXEL, ring[i]);
    send_item(KIND_PIXEL, 8'hA5);
    send_drains(3, 1'b0);
    settle();

    // Width and height below range, threshold above every response
    configure(0, 0, 2047);
    send_rows(3, 3, PIX_EXTREME, 1'b1, -1);
    send_drains(3, 1'b1);
    settle();

    configure(2, 1, 1);
    send_rows(3, 3, PIX_UNIFORM, 1'b0, -1);
    send_drains(3, 1'b0);
    settle();

    // Tall frame cut short: drop the height below the current row, then flush
    configure(3, 65535, 300);
    send_rows(3, 6, PIX_SPARSE, 1'b1, 3);
    settle();
    configure(3, 3, 300);
    send_drains(3, 1'b0);
    settle();

    // Random settings, a few frames each
    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_cfg = $urandom_range(0, 2);
        1:       w_cfg = $urandom_range(17, 48);
        default: w_cfg = $urandom_range(3, 16);
      endcase
      h_cfg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      case ($urandom_range(0, 4))
        0:       thr_cfg = 0;
        1:       thr_cfg = $urandom_range(1, 255);
        2:       thr_cfg = $urandom_range(256, 1200);
        3:       thr_cfg = 2047;
        default: thr_cfg = $urandom_range(0, 2047);
      endcase
      configure(w_cfg, h_cfg, thr_cfg);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        steady   <= ($urandom_range(0, 4) == 0);
        mode     = pixel_mode_t'($urandom_range(0, 3));
        hold_row = ($urandom_range(0, 5) == 0) ?
                   $urandom_range(0, eff_height(h_cfg) - 1) : -1;
        send_rows(eff_width(w_cfg), eff_height(h_cfg), mode,
                  $urandom_range(0, 2) == 0, hold_row);
        send_drains(eff_width(w_cfg), $urandom_range(0, 2) == 0);
      end
      steady <= 1'b0;
      settle();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
